// ----- rtl/key_trail_led_decay_unit_defines.svh -----
// assertion helpers used by the checker file
`ifndef KEY_TRAIL_LED_DECAY_UNIT_DEFINES_SVH
`define KEY_TRAIL_LED_DECAY_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define KTLD_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define KTLD_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ktld_pkg.sv -----
package ktld_pkg;

   // key matrix
   localparam int ROW_COUNT = 4;
   localparam int COL_COUNT = 16;
   localparam int KEY_TOTAL = ROW_COUNT * COL_COUNT;
   localparam int KEY_AW    = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;
   localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int COL_W     = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;

   // writes per pass
   localparam int MAX_WRITES = 64;
   localparam int CNT_W      = $clog2(MAX_WRITES + 1);

   // word fields
   localparam int LEVEL_W   = 8;
   localparam int LED_ROW_W = 2;
   localparam int LED_COL_W = 4;
   localparam int TIME_W    = 32;
   localparam int STEP_W    = 16;
   localparam int MODE_W    = 2;

   // register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic [CSR_AW-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_STEP_LEN = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_HL_RED   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_HL_GREEN = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_HL_BLUE  = 3'd4;

   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HAUNT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRAIL = 2'd2;

   localparam logic [STEP_W-1:0] STEP_LEN_RESET = 16'd50;

   // intensity thresholds
   localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'hff;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH  = 8'hf0;
   localparam logic [LEVEL_W-1:0] LEVEL_MID   = 8'h40;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 8'd32;
   localparam logic [LEVEL_W-1:0] STEP_MID    = 8'd16;
   localparam logic [LEVEL_W-1:0] GREEN_KNEE  = 8'h80;
   localparam logic [LEVEL_W-1:0] GREEN_BASE  = 8'ha0;

   typedef struct packed {
      logic              func;
      logic [7:0]        key_row;
      logic [7:0]        key_col;
      logic              pressed;
      logic [TIME_W-1:0] now_ms;
      logic              post_clear;
   } req_type;

   typedef struct packed {
      logic [LED_ROW_W-1:0] led_row;
      logic [LED_COL_W-1:0] led_col;
      logic [LEVEL_W-1:0]   red;
      logic [LEVEL_W-1:0]   green;
      logic [LEVEL_W-1:0]   blue;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic              take;
      logic              s1_vld;
      logic              flush;
      logic [KEY_AW-1:0] s1_idx;
      logic [ROW_W-1:0]  s1_row;
      logic [COL_W-1:0]  s1_col;
      logic [KEY_AW-1:0] rd_addr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic loop_go;
      logic advance_ok;
      logic pend_vld;
      logic out_free;
   } ctrl_stat_type;

   function automatic logic [LEVEL_W-1:0] decay_level(input logic [LEVEL_W-1:0] lvl);
      logic [LEVEL_W-1:0] res;
      if (lvl >= LEVEL_HIGH) begin
         res = lvl - LEVEL_W'(1);
      end else if (lvl >= LEVEL_MID) begin
         res = lvl - STEP_MID;
      end else if (lvl >= LEVEL_LOW) begin
         res = lvl - LEVEL_LOW;
      end else begin
         res = '0;
      end
      return res;
   endfunction

   // floor(lvl * hl / 255) by reciprocal with correction, exact below 2^16
   function automatic logic [LEVEL_W-1:0] scale_channel(input logic [LEVEL_W-1:0] lvl,
                                                        input logic [LEVEL_W-1:0] hl);
      logic [15:0] prod;
      logic [16:0] sum;
      prod = 16'(lvl) * 16'(hl);
      sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

   function automatic logic [LEVEL_W-1:0] trail_green(input logic [LEVEL_W-1:0] lvl);
      logic [LEVEL_W-1:0] res;
      if (lvl < GREEN_KNEE) begin
         res = lvl;
      end else if (lvl < LEVEL_HIGH) begin
         res = GREEN_BASE - {1'b0, lvl[LEVEL_W-1:1]};
      end else begin
         res = '0;
      end
      return res;
   endfunction

endpackage

// ----- rtl/ktld_ram.sv -----
module ktld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/ktld_ctrl.sv -----
module ktld_ctrl
   import ktld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
   localparam logic [ST_W-1:0] ST_SCAN  = 2'd1;
   localparam logic [ST_W-1:0] ST_FLUSH = 2'd2;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [KEY_AW-1:0] idx_ff, idx_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      req_ready   = (state_ff == ST_IDLE);
      cmd.take    = req_valid && req_ready;
      cmd.s1_vld  = 1'b0;
      cmd.flush   = 1'b0;
      cmd.s1_idx  = idx_ff;
      cmd.s1_row  = row_ff;
      cmd.s1_col  = col_ff;
      cmd.rd_addr = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // first entry is read while the pass is taken
            cmd.rd_addr = '0;
            if (cmd.take && stat.loop_go) begin
               state_in = ST_SCAN;
               idx_in   = '0;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_SCAN: begin
            cmd.s1_vld = 1'b1;
            if (stat.advance_ok) begin
               if (idx_ff == KEY_AW'(KEY_TOTAL - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in      = idx_ff + KEY_AW'(1);
                  cmd.rd_addr = idx_ff + KEY_AW'(1);
                  if (col_ff == COL_W'(COL_COUNT - 1)) begin
                     col_in = '0;
                     row_in = row_ff + ROW_W'(1);
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_vld) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      row_ff <= row_in;
      col_ff <= col_in;
   end

endmodule

// ----- rtl/ktld_datapath.sv -----
module ktld_datapath
   import ktld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_word,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata,
   input  ctrl_cmd_type      cmd,
   output ctrl_stat_type     stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_word
);

   // configuration
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [STEP_W-1:0]  step_len_ff, step_len_in;
   logic [LEVEL_W-1:0] hl_red_ff, hl_red_in;
   logic [LEVEL_W-1:0] hl_green_ff, hl_green_in;
   logic [LEVEL_W-1:0] hl_blue_ff, hl_blue_in;

   // pass state
   logic [TIME_W-1:0]    step_start_ff, step_start_in;
   logic                 due_ff, due_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [KEY_TOTAL-1:0] vld_ff, vld_in;

   // pending and output words
   logic    pend_vld_ff, pend_vld_in;
   rsp_type pend_ff, pend_in;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff, out_in;

   // store port
   logic               ram_we;
   logic [KEY_AW-1:0]  ram_waddr;
   logic [LEVEL_W-1:0] ram_wdata;
   logic [LEVEL_W-1:0] ram_rdata;

   logic               key_hit;
   logic [KEY_AW-1:0]  key_addr;
   logic               due;
   logic [LEVEL_W-1:0] lvl;
   logic [LEVEL_W-1:0] nxt;
   logic               emit;
   logic               adv;
   logic               out_free;
   rsp_type            new_word;

   ktld_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (KEY_TOTAL)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cmd.rd_addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      key_hit  = cmd.take && !req_word.func && req_word.pressed &&
                 (int'(req_word.key_row) < ROW_COUNT) &&
                 (int'(req_word.key_col) < COL_COUNT);
      key_addr = KEY_AW'(int'(req_word.key_row) * COL_COUNT + int'(req_word.key_col));
      due      = (req_word.now_ms - step_start_ff) >= TIME_W'(step_len_ff);

      lvl  = vld_ff[cmd.s1_idx] ? ram_rdata : '0;
      nxt  = due_ff ? decay_level(lvl) : lvl;
      emit = (lvl != '0) && (count_ff < CNT_W'(MAX_WRITES));

      out_free = !out_vld_ff || rsp_ready;

      stat.loop_go    = req_word.func && !req_word.post_clear &&
                        ((mode_ff == MODE_HAUNT) || (mode_ff == MODE_TRAIL));
      stat.advance_ok = !(emit && pend_vld_ff && !out_free);
      stat.pend_vld   = pend_vld_ff;
      stat.out_free   = out_free;

      adv = cmd.s1_vld && stat.advance_ok;

      ram_we    = key_hit || adv;
      ram_waddr = adv ? cmd.s1_idx : key_addr;
      ram_wdata = adv ? nxt : LEVEL_FULL;

      new_word.led_row = LED_ROW_W'(cmd.s1_row);
      new_word.led_col = LED_COL_W'(cmd.s1_col);
      new_word.last    = 1'b0;
      if (nxt == '0) begin
         // key goes dark in this pass
         new_word.red   = '0;
         new_word.green = '0;
         new_word.blue  = '0;
      end else if (mode_ff == MODE_HAUNT) begin
         new_word.red   = scale_channel(lvl, hl_red_ff);
         new_word.green = scale_channel(lvl, hl_green_ff);
         new_word.blue  = scale_channel(lvl, hl_blue_ff);
      end else begin
         new_word.red   = lvl;
         new_word.green = trail_green(lvl);
         new_word.blue  = '0;
      end
   end

   // register writes
   always_comb begin
      mode_in     = mode_ff;
      step_len_in = step_len_ff;
      hl_red_in   = hl_red_ff;
      hl_green_in = hl_green_ff;
      hl_blue_in  = hl_blue_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MODE:     mode_in     = csr_wdata[MODE_W-1:0];
            CSR_STEP_LEN: step_len_in = csr_wdata[STEP_W-1:0];
            CSR_HL_RED:   hl_red_in   = csr_wdata[LEVEL_W-1:0];
            CSR_HL_GREEN: hl_green_in = csr_wdata[LEVEL_W-1:0];
            CSR_HL_BLUE:  hl_blue_in  = csr_wdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      step_start_in = step_start_ff;
      due_in        = due_ff;
      count_in      = count_ff;
      vld_in        = vld_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      out_vld_in    = out_vld_ff && !rsp_ready;

      if (cmd.take && stat.loop_go) begin
         due_in   = due;
         count_in = '0;
         if (due) begin
            step_start_in = req_word.now_ms;
         end
      end
      if (key_hit) begin
         vld_in[key_addr] = 1'b1;
      end
      if (adv) begin
         vld_in[cmd.s1_idx] = 1'b1;
         if (emit) begin
            if (pend_vld_ff) begin
               out_in     = pend_ff;
               out_vld_in = 1'b1;
            end
            pend_in     = new_word;
            pend_vld_in = 1'b1;
            count_in    = count_ff + CNT_W'(1);
         end
      end
      if (cmd.flush) begin
         out_in      = pend_ff;
         out_in.last = 1'b1;
         out_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NONE;
         step_len_ff   <= STEP_LEN_RESET;
         hl_red_ff     <= '0;
         hl_green_ff   <= '0;
         hl_blue_ff    <= '0;
         step_start_ff <= '0;
         vld_ff        <= '0;
         pend_vld_ff   <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         step_len_ff   <= step_len_in;
         hl_red_ff     <= hl_red_in;
         hl_green_ff   <= hl_green_in;
         hl_blue_ff    <= hl_blue_in;
         step_start_ff <= step_start_in;
         vld_ff        <= vld_in;
         pend_vld_ff   <= pend_vld_in;
         out_vld_ff    <= out_vld_in;
      end
      due_ff   <= due_in;
      count_ff <= count_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

endmodule

// ----- rtl/key_trail_led_decay_unit.sv -----
// Key trail LED decay unit. Holds an 8-bit intensity for each key of the
// matrix in a small RAM. A key event word with pressed set lights its key at
// full intensity; a released or out-of-range key changes nothing. A loop
// word, when mode is haunt or trail and post_clear is low, walks the keys in
// row-major order and returns one LED word per lit key, the last one flagged;
// when a decay step is due the intensities decay as they are walked and the
// step start moves to now. Key events and skipped loop words leave the unit
// ready again at once; an active loop word keeps it busy until its walk is
// done, the intensity RAM reading one entry per cycle while the walk is not
// stalled. A stall on the result side holds the walk only while a lit key
// finds both the pending and the output word full, or while the final word
// waits to move out. No clearing pass after reset: one valid bit per key in
// flip-flops marks entries never written as dark. The next word is accepted
// while the final LED word still waits.
module key_trail_led_decay_unit
   import ktld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // input words
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_word,
   // LED words
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_word,
   // register writes
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // sequencer: walk index, pass state, flush of the final word
   ktld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // intensity store, colour maths, pending and output word registers
   ktld_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- rtl/ktld_chk.sv -----
`include "key_trail_led_decay_unit_defines.svh"

module ktld_chk
   import ktld_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input req_type           req_word,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rsp_type           rsp_word,
   input logic              csr_we,
   input logic [CSR_AW-1:0] csr_addr,
   input logic [CSR_DW-1:0] csr_wdata
);

   // shadow of the mode register
   logic [MODE_W-1:0] mode_ff, mode_in;

   always_comb begin
      mode_in = mode_ff;
      if (csr_we && (csr_addr == CSR_MODE)) begin
         mode_in = csr_wdata[MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   `KTLD_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled LED word dropped or changed")
   `KTLD_NEXT(a_ready_back, req_valid && req_ready && (!req_word.func || req_word.post_clear), req_ready, "not ready after a single-cycle word")
   `KTLD_HOLDS(a_trail_colour, rsp_valid && (mode_ff == MODE_TRAIL), (rsp_word.blue == '0) && (rsp_word.green <= rsp_word.red), "trail colour out of shape")
   `KTLD_NEXT(a_idle_quiet, !rsp_valid && (mode_ff != MODE_HAUNT) && (mode_ff != MODE_TRAIL), !rsp_valid, "LED word with colour rule off")

endmodule

bind key_trail_led_decay_unit ktld_chk u_chk (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ktld_pkg::*;

   // word kinds on the input channel
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_LOOP = 1'b1;

   // mode code with no meaning, the loop must stay idle under it
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // settle time covers a walk over the key store, with margin
   localparam int SETTLE_CYCLES  = KEY_TOTAL + 16;
   localparam int WATCHDOG_LIMIT = 4000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_word = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_word;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = CSR_MODE;
   logic [CSR_DW-1:0] csr_wdata = '0;

   // words still to be offered, LED words still owed by the unit
   req_type words_to_send [$];
   rsp_type led_writes_due [$];

   // shadow of the key store, the step timer and the registers
   logic [LEVEL_W-1:0] key_level [KEY_TOTAL];
   logic [TIME_W-1:0]  step_start = '0;
   logic [MODE_W-1:0]  cfg_mode = MODE_NONE;
   logic [STEP_W-1:0]  cfg_step_len = STEP_LEN_RESET;
   logic [LEVEL_W-1:0] cfg_hl_red = '0;
   logic [LEVEL_W-1:0] cfg_hl_green = '0;
   logic [LEVEL_W-1:0] cfg_hl_blue = '0;

   // running millisecond time handed to loop words
   logic [TIME_W-1:0] now_cur = '0;

   int fail_count = 0;
   int stuck_cycles = 0;
   int req_wait = 0;
   int req_calm = 0;
   int rsp_wait = 0;
   int rsp_calm = 0;

   key_trail_led_decay_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // idle gap for one word, drawn at random, with runs of back-to-back words
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(4, 24);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // floor(level * hl / 255), exact in integer arithmetic
   function automatic logic [LEVEL_W-1:0] scaled(input logic [LEVEL_W-1:0] level,
                                                  input logic [LEVEL_W-1:0] hl);
      return LEVEL_W'((int'(level) * int'(hl)) / 255);
   endfunction

   // key event word; the time and skip fields are don't-care here, so toss them
   function automatic req_type key_word(input int row, input int col, input logic down);
      req_type w;
      w.func       = FUNC_KEY;
      w.key_row    = 8'(row);
      w.key_col    = 8'(col);
      w.pressed    = down;
      w.now_ms     = $urandom;
      w.post_clear = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // loop word; key fields are don't-care
   function automatic req_type loop_word(input logic [TIME_W-1:0] now, input logic skip);
      req_type w;
      w.func       = FUNC_LOOP;
      w.key_row    = 8'($urandom_range(0, 255));
      w.key_col    = 8'($urandom_range(0, 255));
      w.pressed    = 1'($urandom_range(0, 1));
      w.now_ms     = now;
      w.post_clear = skip;
      return w;
   endfunction

   // LED words one accepted input word gives rise to, updating the shadow state
   function automatic void predict_led_writes(input req_type w);
      logic [TIME_W-1:0]  elapsed;
      logic               due;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] nxt;
      rsp_type            led;
      rsp_type            held;
      logic               have_held;
      int                 count;
      have_held = 1'b0;
      count     = 0;
      held      = '0;
      if (w.func == FUNC_KEY) begin
         // out-of-range and released keys leave the store alone
         if (w.key_row < ROW_COUNT && w.key_col < COL_COUNT && w.pressed)
            key_level[int'(w.key_row) * COL_COUNT + int'(w.key_col)] = LEVEL_FULL;
         return;
      end
      // skipped pass: no words, no decay, timer untouched
      if (w.post_clear || !(cfg_mode == MODE_HAUNT || cfg_mode == MODE_TRAIL))
         return;
      // wrapped difference, so a time that rolled over still counts
      elapsed = w.now_ms - step_start;
      due     = elapsed >= TIME_W'(cfg_step_len);
      for (int k = 0; k < KEY_TOTAL; k++) begin
         level = key_level[k];
         if (!due) begin
            nxt = level;
         end else if (level >= LEVEL_HIGH) begin
            nxt = level - 8'd1;
         end else if (level >= LEVEL_MID) begin
            nxt = level - STEP_MID;
         end else if (level >= LEVEL_LOW) begin
            nxt = level - LEVEL_LOW;
         end else begin
            nxt = '0;
         end
         key_level[k] = nxt;
         if (level != '0 && count < MAX_WRITES) begin
            led         = '0;
            led.led_row = LED_ROW_W'(k / COL_COUNT);
            led.led_col = LED_COL_W'(k % COL_COUNT);
            // colour from the level before decay; a key going dark gets black
            if (nxt != '0) begin
               if (cfg_mode == MODE_HAUNT) begin
                  led.red   = scaled(level, cfg_hl_red);
                  led.green = scaled(level, cfg_hl_green);
                  led.blue  = scaled(level, cfg_hl_blue);
               end else begin
                  led.red = level;
                  if (level < GREEN_KNEE) begin
                     led.green = level;
                  end else if (level < LEVEL_HIGH) begin
                     led.green = GREEN_BASE - (level >> 1);
                  end else begin
                     led.green = '0;
                  end
               end
            end
            // hold one back so the final word of the pass can be flagged
            if (have_held)
               led_writes_due.push_back(held);
            held      = led;
            have_held = 1'b1;
            count++;
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         led_writes_due.push_back(held);
      end
      if (due)
         step_start = w.now_ms;
   endfunction

   // register write, shadow updated at once; unused upper bits sometimes carry junk
   task automatic write_reg(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] junk;
      junk = ($urandom_range(0, 1) == 1) ? CSR_DW'($urandom) : '0;
      case (addr)
         CSR_MODE: begin
            cfg_mode = value[MODE_W-1:0];
            value    = {junk[CSR_DW-1:MODE_W], value[MODE_W-1:0]};
         end
         CSR_STEP_LEN: begin
            cfg_step_len = value;
         end
         CSR_HL_RED: begin
            cfg_hl_red = value[7:0];
            value      = {junk[15:8], value[7:0]};
         end
         CSR_HL_GREEN: begin
            cfg_hl_green = value[7:0];
            value        = {junk[15:8], value[7:0]};
         end
         CSR_HL_BLUE: begin
            cfg_hl_blue = value[7:0];
            value       = {junk[15:8], value[7:0]};
         end
         default: begin
         end
      endcase
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // all words sent and all LED words back, then let a trailing empty walk finish
   task automatic wait_quiet();
      while (words_to_send.size() != 0 || req_valid || led_writes_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random mix of loop passes and key events; loop times move on by about a step
   task automatic queue_random(input int n, input int loop_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < loop_pct) begin
            if ($urandom_range(0, 9) == 0) begin
               now_cur = $urandom;
            end else begin
               now_cur = now_cur + $urandom_range(0, 2 * int'(cfg_step_len) + 2);
            end
            words_to_send.push_back(loop_word(now_cur, $urandom_range(0, 11) == 0));
         end else if ($urandom_range(0, 7) == 0) begin
            // noise: any row and column, any state
            words_to_send.push_back(key_word($urandom_range(0, 255), $urandom_range(0, 255),
                                             1'($urandom_range(0, 1))));
         end else begin
            words_to_send.push_back(key_word($urandom_range(0, ROW_COUNT - 1),
                                             $urandom_range(0, COL_COUNT - 1),
                                             $urandom_range(0, 4) != 0));
         end
      end
   endtask

   // input driver: one word at a time, random gap after each acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_led_writes(req_word);
         if (!req_valid || req_ready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
               req_word  <= words_to_send.pop_front();
               req_valid <= 1'b1;
               req_wait = draw_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // LED word monitor: compare against the oldest owed word, stall at random
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (led_writes_due.size() == 0) begin
               $error("LED word with none owed: row %0d col %0d",
                      rsp_word.led_row, rsp_word.led_col);
               fail_count++;
            end else begin
               want = led_writes_due.pop_front();
               if (rsp_word.led_row !== want.led_row) begin
                  $error("led_row: expected %0d, got %0d", want.led_row, rsp_word.led_row);
                  fail_count++;
               end
               if (rsp_word.led_col !== want.led_col) begin
                  $error("led_col: expected %0d, got %0d", want.led_col, rsp_word.led_col);
                  fail_count++;
               end
               if (rsp_word.red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_word.red);
                  fail_count++;
               end
               if (rsp_word.green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_word.green);
                  fail_count++;
               end
               if (rsp_word.blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_word.blue);
                  fail_count++;
               end
               if (rsp_word.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_word.last);
                  fail_count++;
               end
            end
            rsp_wait = draw_gap(rsp_calm);
         end else if (rsp_valid && rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   // watchdog on cycles with no traffic on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("key_trail_led_decay_unit test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int order [KEY_TOTAL];
      int j;
      int t;
      foreach (key_level[k])
         key_level[k] = '0;

      // --- directed, reset settings: mode none ---
      words_to_send.push_back(key_word(0, 0, 1'b1));
      // loop ignored while mode is none
      words_to_send.push_back(loop_word(32'd100, 1'b0));
      // row and column just past the matrix, and the far corner of the field
      words_to_send.push_back(key_word(ROW_COUNT, 0, 1'b1));
      words_to_send.push_back(key_word(0, COL_COUNT, 1'b1));
      words_to_send.push_back(key_word(255, 255, 1'b1));
      // release changes nothing
      words_to_send.push_back(key_word(ROW_COUNT - 1, COL_COUNT - 1, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait_quiet();

      // --- trail, zero step length: every pass decays ---
      write_reg(CSR_MODE, CSR_DW'(MODE_TRAIL));
      write_reg(CSR_STEP_LEN, 16'd0);
      write_reg(CSR_HL_RED, 16'hff);
      write_reg(CSR_HL_GREEN, 16'h00);
      write_reg(CSR_HL_BLUE, 16'h80);
      words_to_send.push_back(key_word(ROW_COUNT - 1, COL_COUNT - 1, 1'b1));
      // post-clear pass is skipped
      words_to_send.push_back(loop_word(32'd5, 1'b1));
      words_to_send.push_back(loop_word(32'hffff_ffff, 1'b0));
      words_to_send.push_back(loop_word(32'd0, 1'b0));
      wait_quiet();

      // --- haunt, longest step: not due, due exactly, due across the wrap ---
      write_reg(CSR_STEP_LEN, 16'hffff);
      write_reg(CSR_MODE, CSR_DW'(MODE_HAUNT));
      words_to_send.push_back(loop_word(32'h0000_0010, 1'b0));
      words_to_send.push_back(loop_word(32'h0000_ffff, 1'b0));
      words_to_send.push_back(key_word(1, 7, 1'b1));
      words_to_send.push_back(loop_word(32'h0000_fffe, 1'b0));
      wait_quiet();

      // unused mode code keeps the loop idle
      write_reg(CSR_MODE, CSR_DW'(MODE_UNUSED));
      words_to_send.push_back(loop_word(32'd0, 1'b0));
      wait_quiet();

      // time rolls over: short of the step, then just on it
      write_reg(CSR_MODE, CSR_DW'(MODE_TRAIL));
      write_reg(CSR_STEP_LEN, 16'd32);
      words_to_send.push_back(loop_word(32'hffff_fff0, 1'b0));
      words_to_send.push_back(loop_word(32'h0000_0008, 1'b0));
      words_to_send.push_back(loop_word(32'h0000_0010, 1'b0));
      wait_quiet();

      // --- random: light the whole matrix in shuffled order, then fade it out ---
      now_cur = 32'h10;
      write_reg(CSR_STEP_LEN, 16'd0);
      for (int k = 0; k < KEY_TOTAL; k++)
         order[k] = k;
      for (int k = KEY_TOTAL - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         t        = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      for (int k = 0; k < KEY_TOTAL; k++)
         words_to_send.push_back(key_word(order[k] / COL_COUNT, order[k] % COL_COUNT, 1'b1));
      // due passes enough to walk a full key nearly down to dark
      queue_random(32, 100);
      wait_quiet();

      // haunt with a random highlight and a short step
      write_reg(CSR_MODE, CSR_DW'(MODE_HAUNT));
      write_reg(CSR_STEP_LEN, 16'($urandom_range(1, 40)));
      write_reg(CSR_HL_RED, 16'($urandom_range(0, 255)));
      write_reg(CSR_HL_GREEN, 16'($urandom_range(0, 255)));
      write_reg(CSR_HL_BLUE, 16'($urandom_range(0, 255)));
      queue_random(5, 60);
      wait_quiet();

      // trail with the longest step
      write_reg(CSR_MODE, CSR_DW'(MODE_TRAIL));
      write_reg(CSR_STEP_LEN, 16'hffff);
      queue_random(3, 60);
      wait_quiet();

      // mode none: keys still light, passes idle
      write_reg(CSR_MODE, CSR_DW'(MODE_NONE));
      queue_random(2, 50);
      wait_quiet();

      // haunt at full highlight, step of one
      write_reg(CSR_MODE, CSR_DW'(MODE_HAUNT));
      write_reg(CSR_STEP_LEN, 16'd1);
      write_reg(CSR_HL_RED, 16'hff);
      write_reg(CSR_HL_GREEN, 16'hff);
      write_reg(CSR_HL_BLUE, 16'hff);
      queue_random(4, 70);
      wait_quiet();

      if (fail_count == 0) begin
         $display("key_trail_led_decay_unit test passed");
      end else begin
         $display("key_trail_led_decay_unit test failed");
      end
      $finish;
   end

endmodule
